>>> hdl/swsr_pkg.sv
// ----------------------------------------------------------------------------
// Single-wire sensor reader package
// Request and result types, register indexes and status codes shared by the
// reader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swsr_pkg;

  localparam int CfgDataW = 20;
  localparam int CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CfgStartLow = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRelease  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeout  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgBitThr   = 2'd3;

  localparam logic [19:0] StartLowReset = 20'd18000;
  localparam logic [9:0]  ReleaseReset  = 10'd40;
  localparam logic [19:0] TimeoutReset  = 20'd10000;
  localparam logic [9:0]  BitThrReset   = 10'd40;

  localparam logic [5:0] FrameBits = 6'd40;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusChecksum = 2'd1;
  localparam logic [1:0] StatusTimeout  = 2'd2;

  typedef struct packed {
    logic start_req;
    logic line_level;
  } swsr_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] humidity;
    logic [7:0] temperature;
  } swsr_out_t;

  function automatic logic [31:0] sat_ticks(input logic [31:0] value,
                                            input logic [31:0] limit);
    return (value > limit) ? limit : value;
  endfunction

endpackage

`default_nettype wire

>>> hdl/swsr_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the four timing registers. Start-low and timeout writes are saturated
// to the tick counter range; release and bit-threshold writes keep bits 9:0.
// ----------------------------------------------------------------------------
`default_nettype none

module swsr_cfg #(
  parameter int TICK_WIDTH = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [swsr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [swsr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic      [TICK_WIDTH-1:0]          start_lim_o,
  output logic      [TICK_WIDTH-1:0]          release_lim_o,
  output logic      [TICK_WIDTH-1:0]          timeout_lim_o,
  output logic      [TICK_WIDTH-1:0]          bit_thr_o
);
  import swsr_pkg::*;

  localparam logic [31:0] TickMax = 32'((64'd1 << TICK_WIDTH) - 64'd1);

  logic [TICK_WIDTH-1:0] start_lim_q, release_lim_q, timeout_lim_q, bit_thr_q;
  logic [TICK_WIDTH-1:0] wdata_sat;

  assign wdata_sat = TICK_WIDTH'(sat_ticks(32'(cfg_wdata_i), TickMax));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_lim_q   <= TICK_WIDTH'(sat_ticks(32'(StartLowReset), TickMax));
      release_lim_q <= TICK_WIDTH'(ReleaseReset);
      timeout_lim_q <= TICK_WIDTH'(sat_ticks(32'(TimeoutReset), TickMax));
      bit_thr_q     <= TICK_WIDTH'(BitThrReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartLow: start_lim_q   <= wdata_sat;
        CfgRelease:  release_lim_q <= TICK_WIDTH'(cfg_wdata_i[9:0]);
        CfgTimeout:  timeout_lim_q <= wdata_sat;
        CfgBitThr:   bit_thr_q     <= TICK_WIDTH'(cfg_wdata_i[9:0]);
        default: begin
        end
      endcase
    end
  end

  assign start_lim_o   = start_lim_q;
  assign release_lim_o = release_lim_q;
  assign timeout_lim_o = timeout_lim_q;
  assign bit_thr_o     = bit_thr_q;

endmodule

`default_nettype wire

>>> hdl/swsr_core.sv
// ----------------------------------------------------------------------------
// Reader sequencer
// Phase state machine, tick counter and frame shifter; advances by one tick
// per accepted request and produces that tick's result.
// ----------------------------------------------------------------------------
`default_nettype none

module swsr_core #(
  parameter int TICK_WIDTH = 20
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire swsr_pkg::swsr_in_t    req_i,
  input  wire logic [TICK_WIDTH-1:0] start_lim_i,
  input  wire logic [TICK_WIDTH-1:0] release_lim_i,
  input  wire logic [TICK_WIDTH-1:0] timeout_lim_i,
  input  wire logic [TICK_WIDTH-1:0] bit_thr_i,
  output swsr_pkg::swsr_out_t        res_o
);
  import swsr_pkg::*;

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhLow     = 3'd1;
  localparam logic [2:0] PhRelease = 3'd2;
  localparam logic [2:0] PhAckLow  = 3'd3;
  localparam logic [2:0] PhAckHigh = 3'd4;
  localparam logic [2:0] PhBitLow  = 3'd5;
  localparam logic [2:0] PhBitHigh = 3'd6;

  logic [2:0]            phase_q, phase_d;
  logic [TICK_WIDTH-1:0] tick_q, tick_d, tick_inc;
  logic [39:0]           shift_q, shift_d;
  logic [5:0]            bits_q, bits_d;
  logic [7:0]            hum_q, hum_d, temp_q, temp_d;
  logic                  done;
  logic [1:0]            status;
  logic                  timed_out;
  logic [7:0]            byte_sum;

  assign tick_inc  = (tick_q == {TICK_WIDTH{1'b1}}) ? tick_q : tick_q + 1'b1;
  assign timed_out = tick_q >= timeout_lim_i;

  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    shift_d  = shift_q;
    bits_d   = bits_q;
    hum_d    = hum_q;
    temp_d   = temp_q;
    done     = 1'b0;
    status   = StatusOk;
    byte_sum = 8'd0;
    case (phase_q)
      PhIdle: begin
        if (req_i.start_req) begin
          phase_d = PhLow;
          tick_d  = TICK_WIDTH'(1);
          shift_d = '0;
          bits_d  = '0;
        end
      end
      PhLow: begin
        if (tick_q >= start_lim_i) begin
          phase_d = PhRelease;
          tick_d  = TICK_WIDTH'(1);
        end else begin
          tick_d = tick_inc;
        end
      end
      PhRelease: begin
        if (tick_q >= release_lim_i) begin
          phase_d = PhAckLow;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhAckLow, PhBitLow: begin
        if (req_i.line_level) begin
          phase_d = (phase_q == PhAckLow) ? PhAckHigh : PhBitHigh;
          tick_d  = (phase_q == PhAckLow) ? '0 : TICK_WIDTH'(1);
        end else if (timed_out) begin
          done   = 1'b1;
          status = StatusTimeout;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhAckHigh: begin
        if (!req_i.line_level) begin
          phase_d = PhBitLow;
          tick_d  = '0;
        end else if (timed_out) begin
          done   = 1'b1;
          status = StatusTimeout;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhBitHigh: begin
        if (!req_i.line_level) begin
          shift_d  = {shift_q[38:0], (tick_q > bit_thr_i)};
          bits_d   = bits_q + 6'd1;
          tick_d   = '0;
          byte_sum = shift_d[39:32] + shift_d[31:24] + shift_d[23:16] + shift_d[15:8];
          if (bits_d >= FrameBits) begin
            hum_d  = shift_d[39:32];
            temp_d = shift_d[23:16];
            status = (byte_sum == shift_d[7:0]) ? StatusOk : StatusChecksum;
            done   = 1'b1;
          end else begin
            phase_d = PhBitLow;
          end
        end else if (timed_out) begin
          done   = 1'b1;
          status = StatusTimeout;
        end else begin
          tick_d = tick_inc;
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase
    if (done) begin
      phase_d = PhIdle;
      tick_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q  <= '0;
      shift_q <= '0;
      bits_q  <= '0;
      hum_q   <= '0;
      temp_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
      hum_q   <= hum_d;
      temp_q  <= temp_d;
    end
  end

  always_comb begin
    res_o.drive_low   = (phase_d == PhLow);
    res_o.busy_res    = (phase_d != PhIdle);
    res_o.done_res    = done;
    res_o.status      = status;
    res_o.humidity    = hum_d;
    res_o.temperature = temp_d;
  end

endmodule

`default_nettype wire

>>> hdl/single_wire_sensor_reader.sv
// ----------------------------------------------------------------------------
// Single-wire sensor reader
// Times the start pulse, acknowledge and 40 data bits of a single-wire
// humidity and temperature sensor, one request per microsecond tick.
// ----------------------------------------------------------------------------
// The result of a request is registered and appears in the cycle after it is taken.
// Throughput: one request per cycle unless the output stalls; phase updates per request.
// A request is taken while the output register is empty or being drained.
// Reset puts the sequencer in idle with cleared counters and the timing
// registers at their default values.
`default_nettype none

module single_wire_sensor_reader #(
  parameter int TICK_WIDTH = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire swsr_pkg::swsr_in_t             in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output swsr_pkg::swsr_out_t                 out_res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [swsr_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [swsr_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import swsr_pkg::*;

  logic [TICK_WIDTH-1:0] start_lim, release_lim, timeout_lim, bit_thr;
  logic                  step;
  swsr_out_t             res;
  swsr_out_t             out_q;
  logic                  out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  swsr_cfg #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_lim_o  (start_lim),
    .release_lim_o(release_lim),
    .timeout_lim_o(timeout_lim),
    .bit_thr_o    (bit_thr)
  );

  swsr_core #(
    .TICK_WIDTH(TICK_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .req_i        (in_req_i),
    .start_lim_i  (start_lim),
    .release_lim_i(release_lim),
    .timeout_lim_i(timeout_lim),
    .bit_thr_i    (bit_thr),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // A finished reading always leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.done_res |-> !out_res_o.busy_res)
    else $error("done reported while still busy");

  // Status carries a code only on the tick a reading ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_res_o.done_res |-> out_res_o.status == StatusOk)
    else $error("status set without done");

  // The line is only pulled low during a reading.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.drive_low |-> out_res_o.busy_res)
    else $error("line driven low while idle");

endmodule

`default_nettype wire

>>> test/reader_monitor.sv
// ----------------------------------------------------------------------------
// Single-wire sensor reader monitor
// Watches the request, result and register ports of the reader, keeps its own
// copy of the sequencer and the timing registers, predicts the result of every
// accepted request and compares each accepted result with the oldest
// prediction. Hands the mismatch count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------
`default_nettype none

module reader_monitor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire swsr_pkg::swsr_in_t            in_req_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire swsr_pkg::swsr_out_t           out_res_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [swsr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [swsr_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                                 errors_o,
  output int                                 pending_o,
  output logic                               reading_o
);
  import swsr_pkg::*;

  typedef enum logic [2:0] {
    PhIdle, PhLow, PhRelease, PhAckLow, PhAckHigh, PhBitLow, PhBitHigh
  } reader_phase_e;

  reader_phase_e phase_q = PhIdle;
  logic [19:0]   ticks_q = '0;
  logic [39:0]   frame_q = '0;
  logic [5:0]    nbits_q = '0;
  logic [7:0]    hum_q = '0;
  logic [7:0]    temp_q = '0;

  logic [19:0]   start_low_q = StartLowReset;
  logic [9:0]    release_q = ReleaseReset;
  logic [19:0]   timeout_q = TimeoutReset;
  logic [9:0]    thr_q = BitThrReset;

  swsr_out_t     expected_ticks[$];
  int            errors = 0;
  int            pending = 0;

  assign errors_o  = errors;
  assign pending_o = pending;
  assign reading_o = (phase_q != PhIdle);

  function automatic void bump_ticks();
    if (ticks_q != '1) ticks_q = ticks_q + 20'd1;
  endfunction

  function automatic bit wait_expired();
    if (ticks_q >= timeout_q) return 1'b1;
    bump_ticks();
    return 1'b0;
  endfunction

  function automatic swsr_out_t advance_reader(input swsr_in_t req);
    logic       done;
    logic [1:0] stat;
    logic [7:0] sum8;
    swsr_out_t  res;
    done = 1'b0;
    stat = StatusOk;
    case (phase_q)
      PhIdle: begin
        if (req.start_req) begin
          phase_q = PhLow;
          ticks_q = 20'd1;
          frame_q = '0;
          nbits_q = '0;
        end
      end
      PhLow: begin
        if (ticks_q >= start_low_q) begin
          phase_q = PhRelease;
          ticks_q = 20'd1;
        end else begin
          bump_ticks();
        end
      end
      PhRelease: begin
        if (ticks_q >= {10'd0, release_q}) begin
          phase_q = PhAckLow;
          ticks_q = '0;
        end else begin
          bump_ticks();
        end
      end
      PhAckLow: begin
        if (req.line_level) begin
          phase_q = PhAckHigh;
          ticks_q = '0;
        end else if (wait_expired()) begin
          done = 1'b1;
          stat = StatusTimeout;
        end
      end
      PhAckHigh: begin
        if (!req.line_level) begin
          phase_q = PhBitLow;
          ticks_q = '0;
        end else if (wait_expired()) begin
          done = 1'b1;
          stat = StatusTimeout;
        end
      end
      PhBitLow: begin
        if (req.line_level) begin
          phase_q = PhBitHigh;
          ticks_q = 20'd1;
        end else if (wait_expired()) begin
          done = 1'b1;
          stat = StatusTimeout;
        end
      end
      PhBitHigh: begin
        if (!req.line_level) begin
          frame_q = {frame_q[38:0], (ticks_q > {10'd0, thr_q})};
          nbits_q = nbits_q + 6'd1;
          ticks_q = '0;
          if (nbits_q >= FrameBits) begin
            hum_q  = frame_q[39:32];
            temp_q = frame_q[23:16];
            sum8   = frame_q[39:32] + frame_q[31:24] + frame_q[23:16] + frame_q[15:8];
            stat   = (sum8 == frame_q[7:0]) ? StatusOk : StatusChecksum;
            done   = 1'b1;
          end else begin
            phase_q = PhBitLow;
          end
        end else if (wait_expired()) begin
          done = 1'b1;
          stat = StatusTimeout;
        end
      end
      default: begin
        phase_q = PhIdle;
        ticks_q = '0;
      end
    endcase
    if (done) begin
      phase_q = PhIdle;
      ticks_q = '0;
    end
    res.drive_low   = (phase_q == PhLow);
    res.busy_res    = (phase_q != PhIdle);
    res.done_res    = done;
    res.status      = done ? stat : StatusOk;
    res.humidity    = hum_q;
    res.temperature = temp_q;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    swsr_out_t want;
    if (!rst_ni) begin
      phase_q     = PhIdle;
      ticks_q     = '0;
      frame_q     = '0;
      nbits_q     = '0;
      hum_q       = '0;
      temp_q      = '0;
      start_low_q = StartLowReset;
      release_q   = ReleaseReset;
      timeout_q   = TimeoutReset;
      thr_q       = BitThrReset;
      expected_ticks.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStartLow: start_low_q = cfg_wdata_i;
          CfgRelease:  release_q = cfg_wdata_i[9:0];
          CfgTimeout:  timeout_q = cfg_wdata_i;
          CfgBitThr:   thr_q = cfg_wdata_i[9:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_ticks.size() == 0) begin
          errors++;
          $display("%0t: result with no request waiting: expected none, actual %h",
                   $time, out_res_i);
        end else begin
          want = expected_ticks.pop_front();
          if (out_res_i !== want) begin
            errors++;
            $display({"%0t: result mismatch: expected drive=%0b busy=%0b done=%0b ",
                      "status=%0d hum=%0d temp=%0d, actual drive=%0b busy=%0b ",
                      "done=%0b status=%0d hum=%0d temp=%0d"},
                     $time, want.drive_low, want.busy_res, want.done_res,
                     want.status, want.humidity, want.temperature,
                     out_res_i.drive_low, out_res_i.busy_res, out_res_i.done_res,
                     out_res_i.status, out_res_i.humidity, out_res_i.temperature);
          end
        end
      end
      if (in_valid_i && in_ready_i) expected_ticks.push_back(advance_reader(in_req_i));
    end
    pending = expected_ticks.size();
  end

endmodule

`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// Single-wire sensor reader testbench
// Plays sensor waveforms into the reader one tick per request: directed
// readings at the register extremes, zero timeout, all-ones bits and bad
// checksums, then random phases of well-formed frames, cut-off frames and
// line noise. Both handshakes idle at random and the result side holds off
// once for a long stretch. The monitor predicts and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import swsr_pkg::*;

  localparam int CutNone    = -1;
  localparam int CutAckLow  = 0;
  localparam int CutAckHigh = 1;
  localparam int CutGap     = 2;
  localparam int CutPulse   = 3;

  localparam int QuietFrom = 100;
  localparam int QuietTo   = 300;
  localparam int HoldAt    = 250;
  localparam int HoldLen   = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  swsr_in_t            in_req = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  swsr_out_t           out_res;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = CfgStartLow;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int   errors;
  int   pending;
  logic reading;
  int   cyc = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   sent = 0;
  int   gap_cap = 2;
  int   cfg_sl = StartLowReset;
  int   cfg_rel = ReleaseReset;
  int   cfg_to = TimeoutReset;
  int   cfg_thr = BitThrReset;

  single_wire_sensor_reader uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  reader_monitor monitor (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_res_i   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (errors),
    .pending_o   (pending),
    .reading_o   (reading)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  function automatic bit take_break();
    if (cyc >= QuietFrom && cyc < QuietTo) return 1'b0;
    return ($urandom_range(0, 99) < 24);
  endfunction

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && sent >= HoldAt) begin
      hold_done = 1'b1;
      hold_left = HoldLen;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !take_break();
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(input bit start, input bit level);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= {start, level};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic hold_line(input bit level, input int n);
    repeat (n) send_tick(1'($urandom_range(0, 1)), level);
  endtask

  task automatic noise(input int n);
    repeat (n) send_tick(($urandom_range(0, 9) == 0), 1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    while (reading) send_tick(1'b0, 1'b0);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_timing(input int sl, input int rel, input int to, input int thr);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgStartLow;
    cfg_wdata <= 20'(sl);
    @(negedge clk);
    cfg_idx   <= CfgRelease;
    cfg_wdata <= {10'($urandom_range(0, 1023)), 10'(rel)};
    @(negedge clk);
    cfg_idx   <= CfgTimeout;
    cfg_wdata <= 20'(to);
    @(negedge clk);
    cfg_idx   <= CfgBitThr;
    cfg_wdata <= {10'($urandom_range(0, 1023)), 10'(thr)};
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    cfg_sl  = sl;
    cfg_rel = rel;
    cfg_to  = to;
    cfg_thr = thr;
  endtask

  // One sensor reading; a cut stretches one wait just past the timeout and
  // stops there.
  task automatic play_frame(input logic [39:0] word, input int cut_stage,
                            input int cut_bit);
    int wmax;
    int n;
    wmax = (cfg_to < gap_cap) ? cfg_to : gap_cap;
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    repeat (((cfg_sl > 0) ? cfg_sl : 1) + ((cfg_rel > 0) ? cfg_rel : 1))
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    n = (cut_stage == CutAckLow) ? cfg_to + 1 : $urandom_range(0, wmax);
    hold_line(1'b0, n);
    if (cut_stage == CutAckLow) return;
    n = (cut_stage == CutAckHigh) ? cfg_to + 2 : $urandom_range(1, wmax + 1);
    hold_line(1'b1, n);
    if (cut_stage == CutAckHigh) return;
    for (int i = 0; i < 40; i++) begin
      if (cut_stage == CutGap && cut_bit == i) begin
        hold_line(1'b0, cfg_to + 2);
        return;
      end
      hold_line(1'b0, $urandom_range(1, wmax + 1));
      if (cut_stage == CutPulse && cut_bit == i) begin
        hold_line(1'b1, ((cfg_to > 0) ? cfg_to : 1) + 1);
        return;
      end
      if (word[39 - i]) n = cfg_thr + $urandom_range(1, 3);
      else n = (cfg_thr > 0) ? $urandom_range(1, cfg_thr) : 1;
      hold_line(1'b1, n);
    end
    hold_line(1'b0, 1);
  endtask

  task automatic random_frame(input bit bad_sum, input int cut_stage);
    logic [31:0] bytes;
    logic [7:0]  sum8;
    bytes = $urandom;
    sum8  = bytes[31:24] + bytes[23:16] + bytes[15:8] + bytes[7:0];
    if (bad_sum) sum8 = sum8 ^ 8'($urandom_range(1, 255));
    play_frame({bytes, sum8}, cut_stage, $urandom_range(0, 39));
  endtask

  initial begin
    int base;
    int thr;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    settle();

    set_timing(20'hFFFFF, 1023, 20'hFFFFF, 1023);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    settle();

    // A zero timeout ends each wait phase on its first waiting sample.
    set_timing(0, 0, 0, 0);
    play_frame('0, CutAckLow, 0);
    play_frame('0, CutAckHigh, 0);
    play_frame('0, CutGap, 0);
    play_frame('0, CutPulse, 0);
    settle();

    // All ones gives a checksum byte that does not match the sum.
    set_timing(0, 0, 20'hFFFFF, 0);
    play_frame({5{8'hFF}}, CutNone, 0);
    settle();

    set_timing(2, 3, 12, 1);
    random_frame(1'b0, CutAckLow);
    random_frame(1'b0, CutAckHigh);
    random_frame(1'b0, CutGap);
    random_frame(1'b0, CutPulse);
    settle();

    repeat (2) begin
      thr = $urandom_range(0, 2);
      set_timing($urandom_range(0, 4), $urandom_range(0, 3), thr + $urandom_range(3, 8), thr);
      base = sent;
      while (sent - base < 60) begin
        case ($urandom_range(0, 9))
          7:       random_frame(1'b1, CutNone);
          8:       random_frame(1'b0, $urandom_range(CutAckLow, CutPulse));
          9:       noise($urandom_range(1, 12));
          default: random_frame(1'b0, CutNone);
        endcase
      end
      settle();
    end

    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
hdl/swsr_pkg.sv
hdl/swsr_cfg.sv
hdl/swsr_core.sv
hdl/single_wire_sensor_reader.sv
test/reader_monitor.sv
test/tb_top.sv
